/* rtl/hrhp_pkg.sv */
package hrhp_pkg;

    localparam int CHAR_W = 8;
    localparam int UPPER_W = 16;
    localparam int ADDR_W = 32;
    localparam int HALF_W = 16;
    localparam int POS_W = 10;
    localparam int COUNT_W = 8;
    localparam int ACC_W = 12;
    localparam int INDEX_W = 7;
    localparam int DIGIT_W = 4;

    localparam logic [UPPER_W-1:0] UPPER_ADDR_RESET = 16'h0800;
    localparam logic [POS_W-1:0] POS_MAX = 10'd1023;
    localparam logic [POS_W-1:0] POS_COUNT_LO = 10'd1;
    localparam logic [POS_W-1:0] POS_COUNT_HI = 10'd2;
    localparam logic [POS_W-1:0] POS_ADDR_LO = 10'd3;
    localparam logic [POS_W-1:0] POS_ADDR_HI = 10'd6;
    localparam logic [POS_W-1:0] POS_TYPE = 10'd8;
    localparam logic [POS_W-1:0] POS_DATA = 10'd9;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA_OFFSET = 8'd55;

    function automatic logic [DIGIT_W-1:0] hex_digit(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                v = c - CHAR_ZERO;
            end else begin
                v = c - CHAR_ALPHA_OFFSET;
            end
            hex_digit = v[DIGIT_W-1:0];
        end
    endfunction

endpackage

/* rtl/hex_record_halfword_parser_core.sv */
// Channel  | Direction | tdata                                   | tuser        | tlast
// s_       | in        | [7:0] char_code                         | record_start | -
// m_       | out       | [31:0] write_address, [47:32] halfword  | -            | last_in_record
// cfg_     | in        | [15:0] upper_address (write only)       | -            | -
//
// The parse logic works on the character in the input register; the record state and the
// result register load when the stage advances, so a character can be taken every cycle
// unless the result register stalls. A result loads as its last character advances.
// Reset is synchronous and active low; the upper address returns to 0x0800.
// A stalled result register holds the parse stage, which in turn holds the input register.
module hex_record_halfword_parser_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [hrhp_pkg::UPPER_W-1:0]          cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [hrhp_pkg::CHAR_W-1:0]           s_tdata,   // [7:0] char_code
    input  logic                                  s_tuser,   // [0] record_start
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [hrhp_pkg::ADDR_W+hrhp_pkg::HALF_W-1:0] m_tdata,
                                                  // [31:0] write_address, [47:32] write_halfword
    output logic                                  m_tlast    // last_in_record
);
    import hrhp_pkg::*;

    logic [UPPER_W-1:0] upper_reg;

    logic               in_valid_reg;
    logic [CHAR_W-1:0]  in_char_reg;
    logic               in_start_reg;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [UPPER_W-1:0] pend_reg, pend_next;
    logic [UPPER_W-1:0] commit_reg, commit_next;
    logic               data_rec_reg, data_rec_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;

    logic               m_valid_reg;
    logic [ADDR_W-1:0]  m_addr_reg, m_addr_next;
    logic [HALF_W-1:0]  m_half_reg, m_half_next;
    logic               m_last_reg, m_last_next;
    logic               emit;

    logic               stage_adv;
    logic [POS_W-1:0]   pos;
    logic [DIGIT_W-1:0] digit;
    logic [HALF_W-1:0]  full;
    logic [INDEX_W-1:0] total;
    logic [ADDR_W-1:0]  base;

    assign stage_adv = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || stage_adv;

    always_comb begin
        pos          = in_start_reg ? '0 : pos_reg;
        digit        = hex_digit(in_char_reg);
        full         = {acc_reg, digit};
        total        = count_reg[COUNT_W-1:1];
        base         = {upper_reg, commit_reg};
        count_next   = count_reg;
        pend_next    = pend_reg;
        commit_next  = commit_reg;
        data_rec_next = in_start_reg ? 1'b0 : data_rec_reg;
        idx_next     = in_start_reg ? '0 : idx_reg;
        acc_next     = in_start_reg ? '0 : acc_reg;
        emit         = 1'b0;
        m_addr_next  = base + {{(ADDR_W-INDEX_W-1){1'b0}}, idx_next, 1'b0};
        m_half_next  = {full[7:0], full[15:8]};
        m_last_next  = ((idx_next + 1'b1) == total);

        if (pos == POS_COUNT_LO || pos == POS_COUNT_HI) begin
            count_next = {count_reg[COUNT_W-DIGIT_W-1:0], digit};
        end else if (pos >= POS_ADDR_LO && pos <= POS_ADDR_HI) begin
            pend_next = {pend_reg[UPPER_W-DIGIT_W-1:0], digit};
        end else if (pos == POS_TYPE) begin
            if (in_char_reg == CHAR_ZERO) begin
                commit_next   = pend_reg;
                data_rec_next = 1'b1;
            end else begin
                data_rec_next = 1'b0;
            end
            idx_next = '0;
            acc_next = '0;
        end else if (pos >= POS_DATA && pos < POS_MAX) begin
            if (pos[1:0] != 2'd0) begin
                acc_next = {acc_next[ACC_W-DIGIT_W-1:0], digit};
            end else begin
                if (data_rec_next && idx_next < total) begin
                    emit     = 1'b1;
                    idx_next = idx_next + 1'b1;
                end
                acc_next = '0;
            end
        end

        pos_next = (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg    <= UPPER_ADDR_RESET;
            in_valid_reg <= 1'b0;
            pos_reg      <= '0;
            count_reg    <= '0;
            pend_reg     <= '0;
            commit_reg   <= '0;
            data_rec_reg <= 1'b0;
            acc_reg      <= '0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                upper_reg <= cfg_wdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (stage_adv) begin
                pos_reg      <= pos_next;
                count_reg    <= count_next;
                pend_reg     <= pend_next;
                commit_reg   <= commit_next;
                data_rec_reg <= data_rec_next;
                acc_reg      <= acc_next;
                idx_reg      <= idx_next;
                m_valid_reg  <= emit;
            end else if (m_tready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (stage_adv && emit) begin
            m_addr_reg <= m_addr_next;
            m_half_reg <= m_half_next;
            m_last_reg <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_half_reg, m_addr_reg};
    assign m_tlast  = m_last_reg;

    a_stall_path: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    a_start_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_adv && in_start_reg) |=> (pos_reg == POS_COUNT_LO && idx_reg == '0))
        else $error("record start did not restart the record state");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tready && !(stage_adv && emit)) |=> !m_valid_reg)
        else $error("result repeated after it was taken");

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_adv && emit) |=> (idx_reg != '0))
        else $error("halfword index did not advance on a write");

endmodule
